>>> hdl/slc_pkg.sv
package slc_pkg;

  // fixed widths of ranks, counters, result fields and configuration
  localparam int RANK_W     = 3;
  localparam int CNT_W      = 32;
  localparam int OUT_SET_W  = 6;
  localparam int OUT_WAY_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [RANK_W-1:0] RANK_MAX = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  // access kinds
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_STORE  = 2'd1;
  localparam logic [1:0] ACT_MODIFY = 2'd2;
  localparam logic [1:0] ACT_FETCH  = 2'd3;

  // outcome codes
  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_MISS  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fetch;
    logic out_free;
  } ctrl_sts_t;

endpackage

>>> hdl/slc_if.sv
interface slc_in_if #(
  parameter int ADDR_BITS = 48
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  logic [ADDR_BITS-1:0] address;

  modport source (output valid, output action, output address, input ready);
  modport sink (input valid, input action, input address, output ready);
endinterface

interface slc_out_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          outcome;
  logic                                second_hit;
  logic [slc_pkg::OUT_SET_W-1:0]       set_index;
  logic [slc_pkg::OUT_WAY_W-1:0]       way_used;
  logic [slc_pkg::CNT_W-1:0]           hit_count;
  logic [slc_pkg::CNT_W-1:0]           miss_count;
  logic [slc_pkg::CNT_W-1:0]           eviction_count;

  modport source (output valid, output outcome, output second_hit, output set_index,
                  output way_used, output hit_count, output miss_count,
                  output eviction_count, input ready);
  modport sink (input valid, input outcome, input second_hit, input set_index,
                input way_used, input hit_count, input miss_count,
                input eviction_count, output ready);
endinterface

>>> hdl/slc_ctrl.sv
module slc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  slc_pkg::ctrl_sts_t sts,
  output slc_pkg::ctrl_cmd_t cmd
);

  slc_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      slc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = !sts.fetch;
          if (!sts.fetch) state_nxt = slc_pkg::ST_UPDATE;
        end
      end
      slc_pkg::ST_UPDATE: begin
        // hold the set read until the result register frees up
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = slc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = slc_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> hdl/slc_dp.sv
module slc_dp #(
  parameter int MAX_SET_BITS = 6,
  parameter int WAYS         = 8,
  parameter int ADDR_BITS    = 48
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [slc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]                     in_action,
  input  logic [ADDR_BITS-1:0]           in_address,
  input  slc_pkg::ctrl_cmd_t             cmd,
  output slc_pkg::ctrl_sts_t             sts,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [1:0]                     out_outcome,
  output logic                           out_second_hit,
  output logic [slc_pkg::OUT_SET_W-1:0]  out_set_index,
  output logic [slc_pkg::OUT_WAY_W-1:0]  out_way_used,
  output logic [slc_pkg::CNT_W-1:0]      out_hit_count,
  output logic [slc_pkg::CNT_W-1:0]      out_miss_count,
  output logic [slc_pkg::CNT_W-1:0]      out_eviction_count
);

  localparam int IDX_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RW       = slc_pkg::RANK_W;
  localparam int CW       = slc_pkg::CNT_W;

  // configuration registers
  logic [2:0] set_bits_r;
  logic [4:0] block_bits_r;
  logic [3:0] ways_used_r;
  logic       cfg_hit;

  assign cfg_hit = cfg_we && (cfg_index == slc_pkg::CFG_SET_BITS ||
                              cfg_index == slc_pkg::CFG_BLOCK_BITS ||
                              cfg_index == slc_pkg::CFG_WAYS_USED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= '0;
      block_bits_r <= '0;
      ways_used_r  <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        slc_pkg::CFG_SET_BITS:   set_bits_r   <= cfg_data[2:0];
        slc_pkg::CFG_BLOCK_BITS: block_bits_r <= cfg_data;
        slc_pkg::CFG_WAYS_USED:  ways_used_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // effective set bits and ways
  logic [3:0] sb;
  logic [4:0] nways;
  assign sb = (4'(set_bits_r) > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : 4'(set_bits_r);
  always_comb begin
    if (ways_used_r == '0) nways = 5'd1;
    else if (5'(ways_used_r) > 5'(WAYS)) nways = 5'(WAYS);
    else nways = 5'(ways_used_r);
  end

  // address split
  logic [ADDR_BITS-1:0] addr_shf;
  logic [IDX_W-1:0]     idx_mask;
  logic [IDX_W-1:0]     in_set;
  logic [ADDR_BITS-1:0] in_tag;
  assign addr_shf = in_address >> block_bits_r;
  assign idx_mask = ~({IDX_W{1'b1}} << sb);
  assign in_set   = addr_shf[IDX_W-1:0] & idx_mask;
  assign in_tag   = in_address >> (6'(block_bits_r) + 6'(sb));

  assign sts.fetch = (in_action == slc_pkg::ACT_FETCH);

  // captured word
  logic [IDX_W-1:0]     set_r;
  logic [ADDR_BITS-1:0] tag_r;
  logic                 modify_r;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set_r    <= in_set;
      tag_r    <= in_tag;
      modify_r <= (in_action == slc_pkg::ACT_MODIFY);
    end
  end

  // set memory, one row per set
  logic [WAYS*ADDR_BITS-1:0] tag_mem  [NUM_SETS];
  logic [WAYS*RW-1:0]        rank_mem [NUM_SETS];
  logic [WAYS-1:0]           vld_mem  [NUM_SETS];
  logic [NUM_SETS-1:0]       row_ok_r;

  logic [WAYS*ADDR_BITS-1:0] rd_tag_r;
  logic [WAYS*RW-1:0]        rd_rank_r;
  logic [WAYS-1:0]           rd_vld_r;
  logic                      rd_ok_r;

  logic [WAYS*ADDR_BITS-1:0] wr_tag;
  logic [WAYS*RW-1:0]        wr_rank;
  logic [WAYS-1:0]           wr_vld;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_tag_r  <= tag_mem[in_set];
      rd_rank_r <= rank_mem[in_set];
      rd_vld_r  <= vld_mem[in_set];
      rd_ok_r   <= row_ok_r[in_set];
    end
    if (cmd.commit) begin
      tag_mem[set_r]  <= wr_tag;
      rank_mem[set_r] <= wr_rank;
      vld_mem[set_r]  <= wr_vld;
    end
  end

  // per-set written flags, dropped on any register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_ok_r <= '0;
    end else if (cfg_hit) begin
      row_ok_r <= '0;
    end else if (cmd.commit) begin
      row_ok_r[set_r] <= 1'b1;
    end
  end

  // way compare, victim choice and rank update
  logic [RW-1:0]    rk  [WAYS];
  logic [WAYS-1:0]  act, vld, hit_v;
  logic             hit, any_inv;
  logic [WAY_W-1:0] hit_way, inv_way, ev_way, way_sel;
  logic [RW-1:0]    best;
  logic [RW:0]      limit;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      act[i]   = (5'(i) < nways);
      vld[i]   = rd_ok_r && rd_vld_r[i];
      rk[i]    = rd_ok_r ? rd_rank_r[i*RW +: RW] : '0;
      hit_v[i] = act[i] && vld[i] && (rd_tag_r[i*ADDR_BITS +: ADDR_BITS] == tag_r);
    end
    hit     = |hit_v;
    any_inv = |(act & ~vld);
    hit_way = '0;
    inv_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (hit_v[i]) hit_way = WAY_W'(i);
      if (act[i] && !vld[i]) inv_way = WAY_W'(i);
    end
    // least recent way, lowest index on a tie
    best   = rk[0];
    ev_way = '0;
    for (int i = 1; i < WAYS; i++) begin
      if (act[i] && rk[i] > best) begin
        best   = rk[i];
        ev_way = WAY_W'(i);
      end
    end
    if (hit) begin
      way_sel = hit_way;
      limit   = {1'b0, rk[hit_way]};
    end else if (any_inv) begin
      way_sel = inv_way;
      limit   = {1'b1, {RW{1'b0}}};
    end else begin
      way_sel = ev_way;
      limit   = {1'b0, best};
    end
    for (int i = 0; i < WAYS; i++) begin
      wr_vld[i] = vld[i] || (WAY_W'(i) == way_sel);
      wr_tag[i*ADDR_BITS +: ADDR_BITS] = (WAY_W'(i) == way_sel && !hit) ? tag_r :
                                         rd_tag_r[i*ADDR_BITS +: ADDR_BITS];
      if (WAY_W'(i) == way_sel) begin
        wr_rank[i*RW +: RW] = '0;
      end else if (act[i] && vld[i] && {1'b0, rk[i]} < limit &&
                   rk[i] != slc_pkg::RANK_MAX) begin
        wr_rank[i*RW +: RW] = rk[i] + 1'b1;
      end else begin
        wr_rank[i*RW +: RW] = rk[i];
      end
    end
  end

  // totals
  logic [CW-1:0] hit_cnt_r, miss_cnt_r, evict_cnt_r;
  logic [CW-1:0] hit1, hit2, miss1, evict1;
  logic          evict;

  assign evict  = !hit && !any_inv;
  assign hit1   = (hit && hit_cnt_r != slc_pkg::CNT_MAX) ? hit_cnt_r + 1'b1 : hit_cnt_r;
  assign hit2   = (modify_r && hit1 != slc_pkg::CNT_MAX) ? hit1 + 1'b1 : hit1;
  assign miss1  = (!hit && miss_cnt_r != slc_pkg::CNT_MAX) ? miss_cnt_r + 1'b1 : miss_cnt_r;
  assign evict1 = (evict && evict_cnt_r != slc_pkg::CNT_MAX) ? evict_cnt_r + 1'b1
                                                             : evict_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
    end else if (cmd.commit) begin
      hit_cnt_r   <= hit2;
      miss_cnt_r  <= miss1;
      evict_cnt_r <= evict1;
    end
  end

  // result register
  logic                          out_valid_r;
  logic [1:0]                    outcome_r;
  logic                          second_r;
  logic [slc_pkg::OUT_SET_W-1:0] oset_r;
  logic [slc_pkg::OUT_WAY_W-1:0] oway_r;
  logic [63:0]                   set_wide;
  logic [31:0]                   way_wide;

  assign set_wide = 64'(set_r);
  assign way_wide = 32'(way_sel);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      outcome_r <= hit ? slc_pkg::OUT_HIT : (evict ? slc_pkg::OUT_EVICT : slc_pkg::OUT_MISS);
      second_r  <= modify_r;
      oset_r    <= set_wide[slc_pkg::OUT_SET_W-1:0];
      oway_r    <= way_wide[slc_pkg::OUT_WAY_W-1:0];
    end
  end

  assign sts.out_free       = !out_valid_r || out_ready;
  assign out_valid          = out_valid_r;
  assign out_outcome        = outcome_r;
  assign out_second_hit     = second_r;
  assign out_set_index      = oset_r;
  assign out_way_used       = oway_r;
  assign out_hit_count      = hit_cnt_r;
  assign out_miss_count     = miss_cnt_r;
  assign out_eviction_count = evict_cnt_r;

endmodule

>>> hdl/set_assoc_lru_cache_lookup_core.sv
// Tag and LRU replacement engine of a set-associative cache. For a load, store or modify
// word the set's row (tags, valid bits, ranks of all ways) is read from the set memory
// in the accept cycle; all ways are then compared, the way is chosen and the row is
// written back from the update state; the single read/write port of the set memory is
// never read and written at once. An instruction fetch word is taken, with no result.
// A result waiting in the output register holds the write-back until it is taken. A
// configuration write invalidates every line at once through per-set flags; no clearing
// pass is needed after reset. Counters saturate and survive configuration writes.
module set_assoc_lru_cache_lookup_core #(
  parameter int MAX_SET_BITS = 6,
  parameter int WAYS         = 8,
  parameter int ADDR_BITS    = 48
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [slc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slc_pkg::CFG_DATA_W-1:0] cfg_data,
  slc_in_if.sink                         in_ch,
  slc_out_if.source                      out_ch
);

  slc_pkg::ctrl_cmd_t cmd;
  slc_pkg::ctrl_sts_t sts;

  // sequencer
  slc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // set memory, compare and totals
  slc_dp #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .WAYS         (WAYS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_action          (in_ch.action),
    .in_address         (in_ch.address),
    .cmd                (cmd),
    .sts                (sts),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_outcome        (out_ch.outcome),
    .out_second_hit     (out_ch.second_hit),
    .out_set_index      (out_ch.set_index),
    .out_way_used       (out_ch.way_used),
    .out_hit_count      (out_ch.hit_count),
    .out_miss_count     (out_ch.miss_count),
    .out_eviction_count (out_ch.eviction_count)
  );

endmodule
